// ----- hdl/bfr_pkg.sv -----
`default_nettype none

package bfr_pkg;

  // frame delimiters
  localparam logic [7:0] START_A = 8'hA0;
  localparam logic [7:0] START_B = 8'hA2;
  localparam logic [7:0] END_A   = 8'hB0;
  localparam logic [7:0] END_B   = 8'hB3;

  // message ids that get an acknowledgement class
  localparam logic [7:0] ID_ACK  = 8'd11;
  localparam logic [7:0] ID_NACK = 8'd12;

  // two length bytes, two checksum bytes and two end bytes around the payload
  localparam int unsigned HDR_BYTES = 6;

  localparam int unsigned SUM_W = 15;

  typedef enum logic [2:0] {
    KIND_PAYLOAD  = 3'd0,
    KIND_GOOD     = 3'd1,
    KIND_BAD_SUM  = 3'd2,
    KIND_BAD_END  = 3'd3,
    KIND_OVERFLOW = 3'd4,
    KIND_ABORT    = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ACK_NONE = 2'd0,
    ACK_ACK  = 2'd1,
    ACK_NACK = 2'd2
  } ack_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  payload_byte;
    logic [9:0]  byte_position;
    logic [7:0]  frame_id;
    logic [15:0] frame_length;
    ack_e        ack_class;
    logic [7:0]  acked_id;
    logic        end_of_frame;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/binary_frame_receiver.sv -----
`default_nettype none

// channel   dir  tdata                          tuser       tlast
// s_axis    in   rx_byte [7:0]                  -           -
// m_axis    out  payload_byte, byte_position,   kind [2:0]  end_of_frame
//                frame_id, frame_length,
//                ack_class, acked_id
//
// one item per cycle sustained while results drain; each byte passes an input register,
// a combinational decode against the frame state, and the result register, so a result
// is loaded into the result register as its byte leaves the input register
// rst_ni clears the frame state, so the receiver waits for a start pair
// a stalled result holds the decode stage; the input register still takes one more item if empty
module binary_frame_receiver #(
  parameter int unsigned FRAME_BUFFER_BYTES = 1030
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // rx_byte [7:0]
  input  wire logic [7:0]  s_axis_tdata,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // payload_byte [7:0], byte_position [17:8], frame_id [25:18],
  // frame_length [41:26], ack_class [43:42], acked_id [51:44], zero [55:52]
  output logic [55:0]      m_axis_tdata,
  // kind [2:0]
  output logic [2:0]       m_axis_tuser,
  output logic             m_axis_tlast,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready
);

  logic             in_valid;
  logic [7:0]       in_byte;
  logic             fire;
  logic             res_valid;
  bfr_pkg::result_t res;
  bfr_pkg::result_t out_res;

  // decode advances whenever an input item is held and the result register is free or being drained
  assign fire = in_valid && (!m_axis_tvalid || m_axis_tready);

  bfr_in_stage u_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .take_i     (fire),
    .valid_o    (in_valid),
    .byte_o     (in_byte)
  );

  bfr_deframe #(
    .FRAME_BUFFER_BYTES (FRAME_BUFFER_BYTES)
  ) u_deframe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .byte_i      (in_byte),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  bfr_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_valid),
    .res_i       (res),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .res_o       (out_res)
  );

  // pack the result item onto the stream
  assign m_axis_tdata = {4'b0000, out_res.acked_id, out_res.ack_class, out_res.frame_length,
                         out_res.frame_id, out_res.byte_position, out_res.payload_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.end_of_frame;

endmodule

`default_nettype wire

// ----- hdl/bfr_in_stage.sv -----
`default_nettype none

// input register, one item deep
module bfr_in_stage (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] in_byte_i,
  input  wire logic       take_i,
  output logic            valid_o,
  output logic [7:0]      byte_o
);

  logic       valid_q;
  logic [7:0] byte_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign byte_o     = byte_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= in_byte_i;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bfr_deframe.sv -----
`default_nettype none

// frame state and per-byte decode
module bfr_deframe #(
  parameter int unsigned FRAME_BUFFER_BYTES = 1030
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       fire_i,
  input  wire logic [7:0] byte_i,
  output logic            res_valid_o,
  output bfr_pkg::result_t res_o
);

  localparam int unsigned CNT_W = $clog2(FRAME_BUFFER_BYTES);
  localparam int unsigned CMP_W = 18;
  localparam logic [CMP_W-1:0] BUF_LIMIT = CMP_W'(FRAME_BUFFER_BYTES);
  localparam logic [CMP_W-1:0] HDR_W     = CMP_W'(bfr_pkg::HDR_BYTES);

  logic                         saw_q, saw_d;
  logic                         in_frame_q, in_frame_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic [15:0]                  len_q, len_d;
  logic [bfr_pkg::SUM_W-1:0]    sum_q, sum_d;
  logic [7:0]                   id_q, id_d;
  logic [7:0]                   acked_q, acked_d;
  logic [15:0]                  rsum_q, rsum_d;
  logic [7:0]                   end_a_q, end_a_d;

  logic                         restart;
  logic [15:0]                  len_new;
  logic [CMP_W-1:0]             pos_w, len_w, idx_w;
  bfr_pkg::result_t             end_res;
  bfr_pkg::result_t             res;
  logic                         res_valid;

  assign restart = saw_q && (byte_i == bfr_pkg::START_B);
  assign len_new = {len_q[15:8], byte_i};
  assign pos_w   = CMP_W'(count_q);
  assign len_w   = CMP_W'(len_q);
  assign idx_w   = pos_w - CMP_W'(2);

  // common fields of an end-of-frame result
  always_comb begin
    end_res              = '0;
    end_res.kind         = bfr_pkg::KIND_ABORT;
    end_res.frame_id     = id_q;
    end_res.frame_length = len_q;
    end_res.ack_class    = bfr_pkg::ACK_NONE;
    end_res.acked_id     = acked_q;
    end_res.end_of_frame = 1'b1;
  end

  always_comb begin
    saw_d      = byte_i == bfr_pkg::START_A;
    in_frame_d = in_frame_q;
    count_d    = count_q;
    len_d      = len_q;
    sum_d      = sum_q;
    id_d       = id_q;
    acked_d    = acked_q;
    rsum_d     = rsum_q;
    end_a_d    = end_a_q;
    res        = '0;
    res_valid  = 1'b0;

    if (restart) begin
      if (in_frame_q) begin
        res       = end_res;
        res_valid = 1'b1;
      end
      in_frame_d = 1'b1;
      count_d    = '0;
      len_d      = '0;
      sum_d      = '0;
      id_d       = '0;
      acked_d    = '0;
      rsum_d     = '0;
      end_a_d    = '0;
    end else if (in_frame_q) begin
      count_d = count_q + CNT_W'(1);
      if (pos_w == CMP_W'(0)) begin
        len_d = {byte_i, 8'h00};
      end else if (pos_w == CMP_W'(1)) begin
        len_d = len_new;
        if (CMP_W'(len_new) + HDR_W > BUF_LIMIT) begin
          in_frame_d         = 1'b0;
          res                = end_res;
          res.kind           = bfr_pkg::KIND_OVERFLOW;
          res.frame_length   = len_new;
          res_valid          = 1'b1;
        end
      end else if (pos_w < len_w + CMP_W'(2)) begin
        sum_d = sum_q + bfr_pkg::SUM_W'(byte_i);
        if (idx_w == CMP_W'(0)) begin
          id_d = byte_i;
        end
        if (idx_w == CMP_W'(1)) begin
          acked_d = byte_i;
        end
        res.kind          = bfr_pkg::KIND_PAYLOAD;
        res.payload_byte  = byte_i;
        res.byte_position = idx_w[9:0];
        res_valid         = 1'b1;
      end else if (pos_w == len_w + CMP_W'(2)) begin
        rsum_d = {byte_i, 8'h00};
      end else if (pos_w == len_w + CMP_W'(3)) begin
        rsum_d = {rsum_q[15:8], byte_i};
      end else if (pos_w == len_w + CMP_W'(4)) begin
        end_a_d = byte_i;
      end else begin
        in_frame_d = 1'b0;
        res        = end_res;
        res_valid  = 1'b1;
        if (end_a_q != bfr_pkg::END_A || byte_i != bfr_pkg::END_B) begin
          res.kind = bfr_pkg::KIND_BAD_END;
        end else if ({1'b0, sum_q} != rsum_q) begin
          res.kind = bfr_pkg::KIND_BAD_SUM;
        end else begin
          res.kind = bfr_pkg::KIND_GOOD;
          if (len_q != 16'd0 && id_q == bfr_pkg::ID_ACK) begin
            res.ack_class = bfr_pkg::ACK_ACK;
          end else if (len_q != 16'd0 && id_q == bfr_pkg::ID_NACK) begin
            res.ack_class = bfr_pkg::ACK_NACK;
          end
        end
      end
    end
  end

  assign res_o       = res;
  assign res_valid_o = fire_i && res_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      saw_q      <= 1'b0;
      in_frame_q <= 1'b0;
      count_q    <= '0;
      len_q      <= '0;
      sum_q      <= '0;
      id_q       <= '0;
      acked_q    <= '0;
      rsum_q     <= '0;
      end_a_q    <= '0;
    end else if (fire_i) begin
      saw_q      <= saw_d;
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      len_q      <= len_d;
      sum_q      <= sum_d;
      id_q       <= id_d;
      acked_q    <= acked_d;
      rsum_q     <= rsum_d;
      end_a_q    <= end_a_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/bfr_out_stage.sv -----
`default_nettype none

// result register toward the downstream side
module bfr_out_stage (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             load_i,
  input  wire bfr_pkg::result_t res_i,
  input  wire logic             out_ready_i,
  output logic                  out_valid_o,
  output bfr_pkg::result_t      res_o
);

  logic             valid_q;
  bfr_pkg::result_t res_q;

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire
